// File: sv/robot_mode_sequencer_defines.svh
// Assertion macros for the robot mode sequencer.
// Used by the top level only; needs a clock named i_clk and a reset named i_rst_n.
`ifndef ROBOT_MODE_SEQUENCER_DEFINES_SVH
`define ROBOT_MODE_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define RMS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("robot_mode_sequencer: same-cycle check failed");
// Antecedent implies consequent in the next cycle.
`define RMS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("robot_mode_sequencer: next-cycle check failed");
`else
`define RMS_ASSERT_IMP(lbl, ante, cons)
`define RMS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: sv/rms_pkg.sv
// Shared types, codes and constants of the robot mode sequencer.
// No dependencies; used by rms_dist, rms_mode and robot_mode_sequencer.
package rms_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WAKE  = 3'd1,
        MODE_TRACK = 3'd2,
        MODE_ALERT = 3'd3,
        MODE_COOL  = 3'd4
    } t_mode;

    localparam logic [2:0] ACT_IDLE    = 3'd0;
    localparam logic [2:0] ACT_THINK   = 3'd1;
    localparam logic [2:0] ACT_GREET   = 3'd2;
    localparam logic [2:0] ACT_RETREAT = 3'd3;
    localparam logic [2:0] ACT_ALERT   = 3'd4;

    localparam logic [1:0] GEST_NONE   = 2'd0;
    localparam logic [1:0] GEST_GREET  = 2'd1;
    localparam logic [1:0] GEST_THINK  = 2'd2;
    localparam logic [1:0] GEST_CENTER = 2'd3;

    localparam logic [1:0] TONE_NONE  = 2'd0;
    localparam logic [1:0] TONE_WAKE  = 2'd1;
    localparam logic [1:0] TONE_GREET = 2'd2;
    localparam logic [1:0] TONE_ALERT = 2'd3;

    localparam logic [7:0] HEAD_CENTER = 8'd90;
    localparam logic [7:0] HEAD_LOOK   = 8'd145;

    localparam logic [4:0] LED_OFF       = 5'd0;
    localparam logic [4:0] LED_IDLE_B    = 5'd24;
    localparam logic [4:0] LED_WAKE_G    = 5'd24;
    localparam logic [4:0] LED_TRACK     = 5'd18;
    localparam logic [4:0] LED_ALERT_R   = 5'd28;
    localparam logic [4:0] LED_COOL_R    = 5'd28;
    localparam logic [4:0] LED_COOL_G    = 5'd20;

    localparam logic [12:0] DIST_RESET = 13'd3200;
    localparam logic [12:0] DIST_MAX   = 13'd8191;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [2:0] REG_ALERT_BELOW   = 3'd0;
    localparam logic [2:0] REG_RECOVER_ABOVE = 3'd1;
    localparam logic [2:0] REG_WAKE_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_TRACK_TIME    = 3'd3;
    localparam logic [2:0] REG_ALERT_HOLD    = 3'd4;
    localparam logic [2:0] REG_COOLDOWN      = 3'd5;
    localparam logic [2:0] REG_BEEP_INTERVAL = 3'd6;

    typedef struct packed {
        logic [12:0] alert_below;
        logic [12:0] recover_above;
        logic [15:0] wake_timeout;
        logic [15:0] track_time;
        logic [15:0] alert_hold;
        logic [15:0] cooldown;
        logic [15:0] beep_interval;
    } t_cfg;

    typedef struct packed {
        logic       press;
        logic       hvalid;
        logic [2:0] hcmd;
    } t_tick;

    typedef struct packed {
        t_mode      mode;
        logic       changed;
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
        logic [7:0] head;
        logic [1:0] gesture;
        logic [1:0] tone;
    } t_result;

    // Echo width in us to distance in 1/16 cm, rounded, saturated to 13 bits.
    function automatic logic [12:0] echo_to_raw(input logic [14:0] echo);
        logic [23:0] prod;
        prod = {9'd0, echo} * 24'd281 + 24'd512;
        echo_to_raw = (prod[23] == 1'b1) ? DIST_MAX : prod[22:10];
    endfunction

endpackage

// File: sv/rms_dist.sv
// Distance filter: EMA of raw echo distance plus hysteresis obstacle flag.
// Depends on rms_pkg.
module rms_dist (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_strobe,
    input  logic        i_timeout,
    input  logic [12:0] i_raw,
    input  logic [12:0] i_alert_below,
    input  logic [12:0] i_recover_above,
    output logic [12:0] o_distance,
    output logic        o_obstacle
);
    logic [12:0] r_dist, n_dist;
    logic        r_obst, n_obst;
    logic [12:0] raw_sel;
    logic [21:0] acc;

    always_comb begin
        raw_sel = i_timeout ? r_dist : i_raw;
        acc     = 22'(r_dist) * 22'd166 + 22'(raw_sel) * 22'd90 + 22'd128;
        n_dist  = r_dist;
        n_obst  = r_obst;
        if (i_strobe) begin
            n_dist = acc[20:8];
            if (!r_obst && (n_dist < i_alert_below)) begin
                n_obst = 1'b1;
            end else if (r_obst && (n_dist > i_recover_above)) begin
                n_obst = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= rms_pkg::DIST_RESET;
            r_obst <= 1'b0;
        end else if (i_en) begin
            r_dist <= n_dist;
            r_obst <= n_obst;
        end
    end

    assign o_distance = n_dist;
    assign o_obstacle = n_obst;
endmodule

// File: sv/rms_mode.sv
// Five-mode sequencer with in-mode timers, pending action and beep timer.
// Depends on rms_pkg.
module rms_mode #(
    parameter int TIMER_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  rms_pkg::t_tick  i_tick,
    input  logic            i_obstacle,
    input  rms_pkg::t_cfg   i_cfg,
    output rms_pkg::t_result o_res
);
    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    rms_pkg::t_mode          r_mode, n_mode;
    logic [2:0]              r_pend, n_pend;
    logic                    r_done, n_done;
    logic                    r_btn, n_btn;
    logic [TIMER_BITS-1:0]   r_tim, n_tim;
    logic [TIMER_BITS-1:0]   r_tsb, n_tsb;
    logic [7:0]              r_head, n_head;
    logic [TIMER_BITS-1:0]   tim_inc, tsb_inc;
    logic                    tim_gt_wake, tim_gt_track, tim_gt_hold, tim_gt_cool;
    logic                    tsb_gt_beep;
    rms_pkg::t_result        res;

    always_comb begin
        tim_inc = (r_tim == '1) ? r_tim : r_tim + 1'b1;
        tsb_inc = (r_tsb == '1) ? r_tsb : r_tsb + 1'b1;
        tim_gt_wake  = CW'(tim_inc) > CW'(i_cfg.wake_timeout);
        tim_gt_track = CW'(tim_inc) > CW'(i_cfg.track_time);
        tim_gt_hold  = CW'(tim_inc) > CW'(i_cfg.alert_hold);
        tim_gt_cool  = CW'(tim_inc) > CW'(i_cfg.cooldown);
        tsb_gt_beep  = CW'(tsb_inc) > CW'(i_cfg.beep_interval);
    end

    always_comb begin
        n_tim  = tim_inc;
        n_tsb  = tsb_inc;
        n_btn  = r_btn | i_tick.press;
        n_pend = i_tick.hvalid ? i_tick.hcmd : r_pend;
        n_done = i_tick.hvalid ? 1'b0 : r_done;
        n_mode = r_mode;
        n_head = r_head;
        res    = '0;
        res.gesture = rms_pkg::GEST_NONE;
        res.tone    = rms_pkg::TONE_NONE;

        unique case (r_mode)
            rms_pkg::MODE_WAKE: begin
                res.green = rms_pkg::LED_WAKE_G;
                if (i_obstacle) begin
                    n_mode = rms_pkg::MODE_ALERT;
                end else if ((n_pend != rms_pkg::ACT_THINK) || tim_gt_wake) begin
                    n_mode = rms_pkg::MODE_TRACK;
                end
            end
            rms_pkg::MODE_TRACK: begin
                res.red   = rms_pkg::LED_TRACK;
                res.green = rms_pkg::LED_TRACK;
                res.blue  = rms_pkg::LED_TRACK;
                if (i_obstacle || (n_pend == rms_pkg::ACT_RETREAT) ||
                    (n_pend == rms_pkg::ACT_ALERT)) begin
                    n_mode = rms_pkg::MODE_ALERT;
                end else begin
                    if (!n_done) begin
                        if (n_pend == rms_pkg::ACT_GREET) begin
                            res.gesture = rms_pkg::GEST_GREET;
                            res.tone    = rms_pkg::TONE_GREET;
                            n_head      = rms_pkg::HEAD_CENTER;
                        end else if (n_pend == rms_pkg::ACT_THINK) begin
                            res.gesture = rms_pkg::GEST_THINK;
                            n_head      = rms_pkg::HEAD_CENTER;
                        end else if (n_pend == rms_pkg::ACT_IDLE) begin
                            res.gesture = rms_pkg::GEST_CENTER;
                            n_head      = rms_pkg::HEAD_CENTER;
                        end
                        n_done = 1'b1;
                    end
                    if (tim_gt_track) begin
                        n_mode = rms_pkg::MODE_COOL;
                    end
                end
            end
            rms_pkg::MODE_ALERT: begin
                res.red = rms_pkg::LED_ALERT_R;
                n_head  = rms_pkg::HEAD_LOOK;
                if (tsb_gt_beep) begin
                    n_tsb    = '0;
                    res.tone = rms_pkg::TONE_ALERT;
                end
                if (!i_obstacle && tim_gt_hold) begin
                    n_mode = rms_pkg::MODE_COOL;
                end
            end
            rms_pkg::MODE_COOL: begin
                res.red   = rms_pkg::LED_COOL_R;
                res.green = rms_pkg::LED_COOL_G;
                n_head    = rms_pkg::HEAD_CENTER;
                if (tim_gt_cool) begin
                    n_pend = rms_pkg::ACT_IDLE;
                    n_mode = rms_pkg::MODE_IDLE;
                end
            end
            default: begin
                res.blue = rms_pkg::LED_IDLE_B;
                n_head   = rms_pkg::HEAD_CENTER;
                if (n_btn) begin
                    n_btn    = 1'b0;
                    n_pend   = rms_pkg::ACT_THINK;
                    res.tone = rms_pkg::TONE_WAKE;
                    n_mode   = rms_pkg::MODE_WAKE;
                end else if (i_obstacle) begin
                    n_mode = rms_pkg::MODE_ALERT;
                end
            end
        endcase

        // Every mode entry goes to a different mode; it restarts the in-mode timer.
        res.changed = (n_mode != r_mode);
        if (res.changed) begin
            n_tim  = '0;
            n_done = 1'b0;
        end
        res.mode = n_mode;
        res.head = n_head;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rms_pkg::MODE_IDLE;
            r_pend <= rms_pkg::ACT_IDLE;
            r_done <= 1'b0;
            r_btn  <= 1'b0;
            r_tim  <= '0;
            r_tsb  <= '0;
            r_head <= rms_pkg::HEAD_CENTER;
        end else if (i_en) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_done <= n_done;
            r_btn  <= n_btn;
            r_tim  <= n_tim;
            r_tsb  <= n_tsb;
            r_head <= n_head;
        end
    end

    assign o_res = res;
endmodule

// File: sv/robot_mode_sequencer.sv
// Top level of the robot mode sequencer: input register, config registers,
// result register. Depends on rms_pkg, rms_dist, rms_mode and the defines header.
`include "robot_mode_sequencer_defines.svh"

// Usage: feed one item per millisecond tick; each item yields exactly one result.
// The block sustains one item per clock cycle while results are taken. An accepted
// item passes through the input register, is worked by one pass of logic (distance
// filter and mode machine) and lands in the result register, from which its result
// is offered. The input register refills while a result waits, so a stalled
// consumer holds at most one item in each register before the input side stalls
// too. Echo widths are converted to distance as they enter
// the input register. Configuration goes through the APB-style port at byte
// addresses 0, 4, ... 24; write it only when no item is in flight. Reads of
// unused addresses return zero and writes there are dropped.
module robot_mode_sequencer #(
    parameter int ECHO_TIMEOUT_US = 25000,
    parameter int TIMER_BITS      = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_sample_strobe,
    input  logic [14:0] i_echo_us,
    input  logic        i_button_press,
    input  logic        i_host_cmd_valid,
    input  logic [2:0]  i_host_cmd,
    // Result item channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_mode,
    output logic        o_mode_changed,
    output logic [4:0]  o_led_red,
    output logic [4:0]  o_led_green,
    output logic [4:0]  o_led_blue,
    output logic [7:0]  o_head_angle,
    output logic [1:0]  o_gesture,
    output logic [1:0]  o_tone,
    output logic        o_obstacle,
    output logic [12:0] o_distance_filtered,
    output logic        o_host_ack,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // ---------------- configuration registers ----------------
    rms_pkg::t_cfg r_cfg;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alert_below   <= 13'd288;
            r_cfg.recover_above <= 13'd384;
            r_cfg.wake_timeout  <= 16'd2500;
            r_cfg.track_time    <= 16'd1800;
            r_cfg.alert_hold    <= 16'd1200;
            r_cfg.cooldown      <= 16'd1500;
            r_cfg.beep_interval <= 16'd700;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rms_pkg::REG_ALERT_BELOW:   r_cfg.alert_below   <= pwdata[12:0];
                rms_pkg::REG_RECOVER_ABOVE: r_cfg.recover_above <= pwdata[12:0];
                rms_pkg::REG_WAKE_TIMEOUT:  r_cfg.wake_timeout  <= pwdata[15:0];
                rms_pkg::REG_TRACK_TIME:    r_cfg.track_time    <= pwdata[15:0];
                rms_pkg::REG_ALERT_HOLD:    r_cfg.alert_hold    <= pwdata[15:0];
                rms_pkg::REG_COOLDOWN:      r_cfg.cooldown      <= pwdata[15:0];
                rms_pkg::REG_BEEP_INTERVAL: r_cfg.beep_interval <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            rms_pkg::REG_ALERT_BELOW:   prdata = 32'(r_cfg.alert_below);
            rms_pkg::REG_RECOVER_ABOVE: prdata = 32'(r_cfg.recover_above);
            rms_pkg::REG_WAKE_TIMEOUT:  prdata = 32'(r_cfg.wake_timeout);
            rms_pkg::REG_TRACK_TIME:    prdata = 32'(r_cfg.track_time);
            rms_pkg::REG_ALERT_HOLD:    prdata = 32'(r_cfg.alert_hold);
            rms_pkg::REG_COOLDOWN:      prdata = 32'(r_cfg.cooldown);
            rms_pkg::REG_BEEP_INTERVAL: prdata = 32'(r_cfg.beep_interval);
            default:                    prdata = '0;
        endcase
    end

    // ---------------- handshake control ----------------
    // Advance the item in the input register when the result register is empty
    // or its item is being taken this cycle.
    logic r_in_valid, r_out_valid;
    logic in_acc, adv;

    assign adv        = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | adv;
    assign in_acc     = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- input register ----------------
    // Convert the echo on the way in; a zero or overlong echo is a timeout and
    // makes the filter reuse its own value.
    logic          r_strobe, r_timeout;
    logic [12:0]   r_raw;
    rms_pkg::t_tick r_tick;
    logic          echo_timeout;

    assign echo_timeout = (i_echo_us == '0) ||
                          (17'(i_echo_us) > 17'(ECHO_TIMEOUT_US));

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_strobe      <= i_sample_strobe;
            r_timeout     <= echo_timeout;
            r_raw         <= rms_pkg::echo_to_raw(i_echo_us);
            r_tick.press  <= i_button_press;
            r_tick.hvalid <= i_host_cmd_valid;
            r_tick.hcmd   <= i_host_cmd;
        end
    end

    // ---------------- single-pass work ----------------
    logic [12:0]      dist_nxt;
    logic             obst_nxt;
    rms_pkg::t_result res;

    rms_dist u_dist (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (adv),
        .i_strobe        (r_strobe),
        .i_timeout       (r_timeout),
        .i_raw           (r_raw),
        .i_alert_below   (r_cfg.alert_below),
        .i_recover_above (r_cfg.recover_above),
        .o_distance      (dist_nxt),
        .o_obstacle      (obst_nxt)
    );

    rms_mode #(
        .TIMER_BITS (TIMER_BITS)
    ) u_mode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (adv),
        .i_tick     (r_tick),
        .i_obstacle (obst_nxt),
        .i_cfg      (r_cfg),
        .o_res      (res)
    );

    // ---------------- result register ----------------
    rms_pkg::t_result r_res;
    logic             r_obst;
    logic [12:0]      r_dist;
    logic             r_ack;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res  <= res;
            r_obst <= obst_nxt;
            r_dist <= dist_nxt;
            r_ack  <= r_tick.hvalid;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_mode              = r_res.mode;
    assign o_mode_changed      = r_res.changed;
    assign o_led_red           = r_res.red;
    assign o_led_green         = r_res.green;
    assign o_led_blue          = r_res.blue;
    assign o_head_angle        = r_res.head;
    assign o_gesture           = r_res.gesture;
    assign o_tone              = r_res.tone;
    assign o_obstacle          = r_obst;
    assign o_distance_filtered = r_dist;
    assign o_host_ack          = r_ack;

    // ---------------- checks ----------------
    logic chk_alert_held, chk_alert_look, chk_wake_tone, chk_wake_entry;

    assign chk_alert_held = r_out_valid && (r_res.mode == rms_pkg::MODE_ALERT) &&
                            !r_res.changed;
    assign chk_alert_look = (r_res.head == rms_pkg::HEAD_LOOK) &&
                            (r_res.red == rms_pkg::LED_ALERT_R);
    assign chk_wake_tone  = r_out_valid && (r_res.tone == rms_pkg::TONE_WAKE);
    assign chk_wake_entry = (r_res.mode == rms_pkg::MODE_WAKE) && r_res.changed;

    // An advanced item always shows up as a result in the next cycle.
    `RMS_ASSERT_NXT(a_adv_fills_out, adv, r_out_valid)
    // A result that stays in alert mode looks aside with red light.
    `RMS_ASSERT_IMP(a_alert_look, chk_alert_held, chk_alert_look)
    // The wake tone only sounds on the tick that enters wake.
    `RMS_ASSERT_IMP(a_wake_tone, chk_wake_tone, chk_wake_entry)
endmodule
